### hdl/hdc_pkg.sv
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared types and constants of the handheld bus decoder and timer.
// ----------------------------------------------------------------------------
`default_nettype none

package hdc_pkg;

    // request command codes
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    // cpu map regions, taken from address bits 15:13
    typedef enum logic [2:0] {
        REGION_WRAM  = 3'd0,
        REGION_IO    = 3'd1,
        REGION_VRAM  = 3'd2,
        REGION_HOLE  = 3'd3,
        REGION_ROMB0 = 3'd4,
        REGION_ROMB1 = 3'd5,
        REGION_ROMF0 = 3'd6,
        REGION_ROMF1 = 3'd7
    } region_t;

    // which memory answered the last read
    typedef enum logic [1:0] {
        RD_WRAM = 2'd0,
        RD_VRAM = 2'd1,
        RD_ROM  = 2'd2
    } rdsrc_t;

    // i/o register addresses
    localparam logic [15:0] ADDR_PAD    = 16'h2020;
    localparam logic [15:0] ADDR_TIMER  = 16'h2023;
    localparam logic [15:0] ADDR_SYSCTL = 16'h2026;
    localparam logic [7:0]  PAD_IDLE    = 8'hff;

    // ram geometry
    localparam int unsigned RAM_BYTES = 8192;
    localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
    localparam int unsigned ROM_WIN   = 16384;
    localparam int unsigned ROM_WIN_AW = $clog2(ROM_WIN);

    // system control bits
    localparam int unsigned CTRL_IRQ_EN_BIT = 1;
    localparam int unsigned CTRL_SLOW_BIT   = 4;
    localparam int unsigned CTRL_BANK_LSB   = 5;

    // prescaler: fast period is 2**PRESC_FAST_SH ticks, slow period wraps the counter
    localparam int unsigned PRESC_W       = 14;
    localparam int unsigned PRESC_FAST_SH = 8;

    // input request
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] bus_addr;
        logic [7:0]  write_data;
        logic [16:0] rom_load_addr;
    } in_t;

    // result
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raise;
        logic       irq_pending;
    } out_t;

    // register file answer for the current request
    typedef struct packed {
        logic [7:0] io_rd;
        logic       irq_raise;
        logic       irq_pending;
    } regs_res_t;

    // ram access for the current request
    typedef struct packed {
        logic              wram_we;
        logic              vram_we;
        logic              rom_we;
        logic              wram_re;
        logic              vram_re;
        logic              rom_re;
        logic [RAM_AW-1:0] ram_addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

`default_nettype wire

### hdl/hdc_regs.sv
// ----------------------------------------------------------------------------
// hdc_regs
// Timer, prescaler, system control and irq status registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_regs (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire hdc_pkg::in_t      req,
    output hdc_pkg::regs_res_t     res,
    output logic [2:0]             rom_bank
);
    import hdc_pkg::*;

    logic [7:0]         timer_reg, timer_next;
    logic [PRESC_W-1:0] presc_reg, presc_next;
    logic [7:0]         ctrl_reg, ctrl_next;
    logic               irq_reg, irq_next;
    logic [PRESC_W-1:0] presc_inc;
    logic               step;
    logic               expire;

    // next register values, irq result and i/o read value for this request
    always_comb begin
        timer_next = timer_reg;
        presc_next = presc_reg;
        ctrl_next  = ctrl_reg;
        irq_next   = irq_reg;
        expire     = 1'b0;
        presc_inc  = presc_reg + PRESC_W'(1);
        // slow period only ends on wrap; fast one also ends once the count reaches 256
        if (ctrl_reg[CTRL_SLOW_BIT]) begin
            step = (presc_inc == '0);
        end else begin
            step = (presc_inc == '0) || (presc_inc[PRESC_W-1:PRESC_FAST_SH] != '0);
        end
        case (req.cmd)
            CMD_WRITE: begin
                if (req.bus_addr == ADDR_TIMER) begin
                    timer_next = req.write_data;
                    presc_next = '0;
                    expire     = (req.write_data == 8'd0);
                end else if (req.bus_addr == ADDR_SYSCTL) begin
                    ctrl_next = req.write_data;
                end
            end
            CMD_TICK: begin
                // a stopped timer ignores ticks
                if (timer_reg != 8'd0) begin
                    presc_next = presc_inc;
                    if (step) begin
                        presc_next = '0;
                        timer_next = timer_reg - 8'd1;
                        expire     = (timer_reg == 8'd1);
                    end
                end
            end
            default: ;
        endcase
        if (expire) begin
            irq_next = 1'b1;
        end
        res.irq_raise   = expire && !irq_reg && ctrl_reg[CTRL_IRQ_EN_BIT];
        res.irq_pending = irq_next;
        // i/o read value
        if (req.bus_addr == ADDR_PAD) begin
            res.io_rd = PAD_IDLE;
        end else if (req.bus_addr == ADDR_TIMER) begin
            res.io_rd = timer_reg;
        end else begin
            res.io_rd = 8'd0;
        end
    end

    assign rom_bank = ctrl_reg[CTRL_BANK_LSB +: 3];

    // register update on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            presc_reg <= '0;
            ctrl_reg  <= '0;
            irq_reg   <= 1'b0;
        end else if (en) begin
            timer_reg <= timer_next;
            presc_reg <= presc_next;
            ctrl_reg  <= ctrl_next;
            irq_reg   <= irq_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hdc_mem.sv
// ----------------------------------------------------------------------------
// hdc_mem
// Work ram, video ram and rom arrays with registered read data and the
// clearing sweep of both rams after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_mem #(
    parameter int unsigned ROM_BYTES = 131072,
    parameter int unsigned RomAw     = $clog2(ROM_BYTES)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hdc_pkg::mem_req_t    req,
    input  wire logic [RomAw-1:0]     rom_addr,
    output logic [7:0]                rd_data,
    output logic                      busy
);
    import hdc_pkg::*;

    logic [7:0]        wram_mem [RAM_BYTES];
    logic [7:0]        vram_mem [RAM_BYTES];
    logic [7:0]        rom_mem  [ROM_BYTES];
    logic [7:0]        wram_rd_reg;
    logic [7:0]        vram_rd_reg;
    logic [7:0]        rom_rd_reg;
    rdsrc_t            rd_sel_reg;
    logic [RAM_AW-1:0] clr_idx_reg;
    logic              busy_reg;

    // clearing sweep, one entry of each ram per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end else if (busy_reg) begin
            clr_idx_reg <= clr_idx_reg + RAM_AW'(1);
            if (clr_idx_reg == RAM_AW'(RAM_BYTES - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;

    // work ram
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            wram_mem[clr_idx_reg] <= 8'd0;
        end else if (req.wram_we) begin
            wram_mem[req.ram_addr] <= req.wdata;
        end
        if (req.wram_re) begin
            wram_rd_reg <= wram_mem[req.ram_addr];
        end
    end

    // video ram
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            vram_mem[clr_idx_reg] <= 8'd0;
        end else if (req.vram_we) begin
            vram_mem[req.ram_addr] <= req.wdata;
        end
        if (req.vram_re) begin
            vram_rd_reg <= vram_mem[req.ram_addr];
        end
    end

    // rom
    always_ff @(posedge aclk) begin
        if (req.rom_we) begin
            rom_mem[rom_addr] <= req.wdata;
        end
        if (req.rom_re) begin
            rom_rd_reg <= rom_mem[rom_addr];
        end
    end

    // remember which array the last read went to
    always_ff @(posedge aclk) begin
        if (req.wram_re) begin
            rd_sel_reg <= RD_WRAM;
        end else if (req.vram_re) begin
            rd_sel_reg <= RD_VRAM;
        end else if (req.rom_re) begin
            rd_sel_reg <= RD_ROM;
        end
    end

    always_comb begin
        case (rd_sel_reg)
            RD_WRAM: rd_data = wram_rd_reg;
            RD_VRAM: rd_data = vram_rd_reg;
            RD_ROM:  rd_data = rom_rd_reg;
            default: rd_data = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/handheld_bus_decoder_with_timer.sv
// ----------------------------------------------------------------------------
// handheld_bus_decoder_with_timer
// Memory map and countdown timer of a small 65C02 handheld.
// Requests enter on the s_ channel (valid/ready, payload s_payload): a cpu
// read, a cpu write, one cpu clock tick or a rom load byte. Every request
// gives exactly one result on the m_ channel (m_payload): read byte, irq
// raise and sticky irq status.
// From acceptance to m_valid a request passes the read stage, which holds
// the synchronous ram read, and then the output register. While the
// receiver keeps up, one request per cycle is taken; ram writes land at the
// accepting edge, so a read that follows the next cycle already sees them.
// After reset both rams are cleared, one entry per cycle, which holds
// s_ready low until all 8192 entries are done. Timer and control
// registers reset to zero; rom contents stay undefined until loaded.
// When the receiver stalls, the result waits in the output register and one
// more request can still enter the read stage; s_ready falls once both are
// full.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_bus_decoder_with_timer #(
    parameter int unsigned ROM_BYTES = 131072
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire hdc_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output hdc_pkg::out_t      m_payload
);
    import hdc_pkg::*;

    localparam int unsigned RomAw    = $clog2(ROM_BYTES);
    localparam int unsigned FixedOff = ROM_BYTES - ROM_WIN;

    logic               accept;
    logic               busy;
    regs_res_t          regs_res;
    logic [2:0]         rom_bank;
    mem_req_t           mreq;
    logic [RomAw-1:0]   rom_addr;
    logic [7:0]         mem_rd;
    region_t            region;
    logic               is_read;
    logic               is_write;
    logic [RomAw-1:0]   bank_base [8];
    logic [RomAw:0]     bank_sum;
    logic [RomAw-1:0]   bank_off;
    logic [RomAw-1:0]   fixed_off;
    logic               load_ok;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_use_mem_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_raise_reg;
    logic               s1_pend_reg;
    logic               s1_adv;
    logic               m_valid_reg, m_valid_next;
    out_t               m_payload_reg;

    // handshake
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !busy && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    // register file
    hdc_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (accept),
        .req      (s_payload),
        .res      (regs_res),
        .rom_bank (rom_bank)
    );

    // rom bank base offsets, wrapped to the rom size
    for (genvar k = 0; k < 8; k++) begin : g_bank
        localparam int unsigned BankBase = (k * ROM_WIN) % ROM_BYTES;
        assign bank_base[k] = RomAw'(BankBase);
    end

    // banked window offset: one compare and subtract keeps it below the rom size
    always_comb begin
        bank_sum = {1'b0, bank_base[rom_bank]}
                 + (RomAw+1)'(s_payload.bus_addr[ROM_WIN_AW-1:0]);
        if (bank_sum >= (RomAw+1)'(ROM_BYTES)) begin
            bank_off = RomAw'(bank_sum - (RomAw+1)'(ROM_BYTES));
        end else begin
            bank_off = bank_sum[RomAw-1:0];
        end
        fixed_off = RomAw'(FixedOff) + RomAw'(s_payload.bus_addr[ROM_WIN_AW-1:0]);
    end

    // address decode into memory access
    assign region   = region_t'(s_payload.bus_addr[15:13]);
    assign is_read  = accept && (s_payload.cmd == CMD_READ);
    assign is_write = accept && (s_payload.cmd == CMD_WRITE);
    assign load_ok  = (32'(s_payload.rom_load_addr) < ROM_BYTES);

    always_comb begin
        mreq          = '0;
        mreq.ram_addr = s_payload.bus_addr[RAM_AW-1:0];
        mreq.wdata    = s_payload.write_data;
        mreq.wram_we  = is_write && (region == REGION_WRAM);
        mreq.vram_we  = is_write && (region == REGION_VRAM);
        mreq.wram_re  = is_read && (region == REGION_WRAM);
        mreq.vram_re  = is_read && (region == REGION_VRAM);
        mreq.rom_re   = is_read && (region == REGION_ROMB0 || region == REGION_ROMB1 ||
                                    region == REGION_ROMF0 || region == REGION_ROMF1);
        mreq.rom_we   = accept && (s_payload.cmd == CMD_LOAD) && load_ok;
        if (s_payload.cmd == CMD_LOAD) begin
            rom_addr = s_payload.rom_load_addr[RomAw-1:0];
        end else if (region == REGION_ROMF0 || region == REGION_ROMF1) begin
            rom_addr = fixed_off;
        end else begin
            rom_addr = bank_off;
        end
    end

    hdc_mem #(
        .ROM_BYTES (ROM_BYTES)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (mreq),
        .rom_addr (rom_addr),
        .rd_data  (mem_rd),
        .busy     (busy)
    );

    // read stage: holds the request while the ram answers
    assign s1_valid_next = accept || (s1_valid_reg && !s1_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_use_mem_reg <= mreq.wram_re || mreq.vram_re || mreq.rom_re;
            s1_byte_reg    <= (is_read && region == REGION_IO) ? regs_res.io_rd : 8'd0;
            s1_raise_reg   <= regs_res.irq_raise;
            s1_pend_reg    <= regs_res.irq_pending;
        end
    end

    // output register
    assign m_valid_next = s1_adv || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_payload_reg.read_data   <= s1_use_mem_reg ? mem_rd : s1_byte_reg;
            m_payload_reg.irq_raise   <= s1_raise_reg;
            m_payload_reg.irq_pending <= s1_pend_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // a raised irq always reports the status bit set
    a_raise_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.irq_raise) |-> m_payload.irq_pending)
        else $error("irq raised without pending status");

    // nothing is taken while the rams are being cleared
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !accept)
        else $error("request accepted during ram clear");

    // an accepted request occupies the read stage next cycle
    a_accept_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted request lost before read stage");

    // a result cannot appear without a request in the read stage before
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result produced without a request");

endmodule

`default_nettype wire
